// ----- src/swle_pkg.sv -----
// shared types and constants of the stop-and-wait link engine
package swle_pkg;

  typedef enum logic [1:0] {
    KIND_S = 2'd0,
    KIND_R = 2'd1,
    KIND_E = 2'd2
  } msg_kind_e;

  localparam logic [7:0] CHAR_S = 8'h53;
  localparam logic [7:0] CHAR_R = 8'h52;
  localparam logic [7:0] CHAR_E = 8'h45;

  localparam logic CFG_TICKS = 1'b0;
  localparam logic CFG_RETRY = 1'b1;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_BYTE = 1'b1;

  localparam logic [15:0] TICKS_RESET = 16'd100;
  localparam logic [7:0]  RETRY_RESET = 8'd5;

  typedef struct packed {
    msg_kind_e  kind;
    logic [7:0] seq;
    logic       last;
  } msg_t;

  // up to two messages produced by one tick, in order
  typedef struct packed {
    logic [1:0] num;
    msg_t       m0;
    msg_t       m1;
  } push_t;

endpackage

// ----- src/stop_and_wait_link_engine.sv -----
// top level of the stop-and-wait link engine
// Input channel (in_valid_i/in_ready_o) takes one word per cycle while ready: a timer tick
// (action_i = 0) or a received radio byte (action_i = 1, rx_data_i).
// Output channel (out_valid_o/out_ready_i) gives one message per transfer:
// kind S/R/E, sequence byte, and last_msg_o on the final message of a tick.
// A tick gives zero, one or two messages; byte words give none.
// A message is written into the message queue when its tick is accepted,
// then moved into the output register, which presents it on the output.
// Throughput: one word per cycle while ticks give at most one message and
// out_ready_i is high; ticks with two messages are limited by the
// one-message-per-cycle output register draining the four-entry message queue.
// Config writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once:
// index 0 is ticks per period, index 1 the retry limit.
// Reset sets the period to 100, retry limit to 5, both sequences to 1.
// When the receiver stalls, messages collect in the queue and in_ready_o
// drops once fewer than two entries are free; nothing is lost.
module stop_and_wait_link_engine #(
  parameter int unsigned SeqModulus = 99
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [7:0]  rx_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  msg_kind_o,
  output logic [7:0]  msg_seq_o,
  output logic        last_msg_o
);
  import swle_pkg::*;

  push_t push;
  logic  space;
  logic  q_pop;
  logic  q_valid;
  msg_t  q_data;
  msg_t  out_msg;

  swle_front #(
    .SeqModulus(SeqModulus)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .rx_data_i  (rx_data_i),
    .space_i    (space),
    .push_o     (push)
  );

  swle_msg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  swle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_msg)
  );

  assign msg_kind_o = out_msg.kind;
  assign msg_seq_o  = out_msg.seq;
  assign last_msg_o = out_msg.last;

endmodule

// ----- src/swle_front.sv -----
// front end: accepts words, keeps link state and classifies frames into messages
module swle_front #(
  parameter int unsigned SeqModulus = 99
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [15:0]      cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             action_i,
  input  logic [7:0]       rx_data_i,
  input  logic             space_i,
  output swle_pkg::push_t  push_o
);
  import swle_pkg::*;

  logic [7:0] seq_tbl [256];

  for (genvar g = 0; g < 256; g++) begin : g_seq_tbl
    localparam int unsigned NextVal = (g % SeqModulus) + 1;
    assign seq_tbl[g] = NextVal[7:0];
  end

  logic [15:0] ticks_q;
  logic [7:0]  retry_q;
  logic [15:0] phase_q, phase_d;
  logic [7:0]  wait_q, wait_d;
  logic [7:0]  send_seq_q, send_seq_d;
  logic [6:0]  expect_q, expect_d;
  logic        cleared_q, cleared_d;
  logic [1:0]  count_q, count_d;
  logic [7:0]  head_q, head_d;
  logic [7:0]  tail_q, tail_d;

  logic        accept;
  logic [16:0] phase_inc;
  logic        elapsed;
  logic        send_s;
  logic        answer;
  msg_kind_e   ans_kind;
  logic [7:0]  expect_ext;
  logic [7:0]  expect_nxt;

  assign accept     = in_valid_i && space_i;
  assign in_ready_o = space_i;
  assign phase_inc  = {1'b0, phase_q} + 17'd1;
  assign elapsed    = (phase_inc[15:0] == ticks_q);
  assign expect_ext = {1'b0, expect_q};
  assign expect_nxt = seq_tbl[expect_ext];

  always_comb begin
    phase_d    = phase_q;
    wait_d     = wait_q;
    send_seq_d = send_seq_q;
    expect_d   = expect_q;
    cleared_d  = cleared_q;
    count_d    = count_q;
    head_d     = head_q;
    tail_d     = tail_q;
    send_s     = 1'b0;
    answer     = 1'b0;
    ans_kind   = KIND_E;
    if (accept) begin
      if (action_i == ACT_BYTE) begin
        if (rx_data_i != 8'd0) begin
          if (count_q == 2'd0) head_d = rx_data_i;
          if (count_q == 2'd1) tail_d = rx_data_i;
          if (count_q != 2'd3) count_d = count_q + 2'd1;
        end
      end else begin
        // period timer and send decision
        if (elapsed) begin
          phase_d = 16'd0;
          if (cleared_q || (wait_q >= retry_q)) begin
            send_s    = 1'b1;
            cleared_d = 1'b0;
            wait_d    = 8'd0;
          end else if (wait_q != 8'd255) begin
            wait_d = wait_q + 8'd1;
          end
        end else begin
          phase_d = phase_inc[15:0];
        end
        // frame evaluation
        if (count_q == 2'd2) begin
          count_d = 2'd0;
          if (head_q == CHAR_R) begin
            send_seq_d = seq_tbl[send_seq_q];
            cleared_d  = 1'b1;
          end else if (head_q == CHAR_E) begin
            send_seq_d = tail_q;
            cleared_d  = 1'b1;
          end else if (head_q == CHAR_S && tail_q == expect_ext) begin
            answer   = 1'b1;
            ans_kind = KIND_R;
            expect_d = expect_nxt[6:0];
          end else begin
            answer = 1'b1;
          end
        end else if (count_q == 2'd3) begin
          count_d = 2'd0;
          answer  = 1'b1;
        end
      end
    end
  end

  always_comb begin
    push_o.num     = {1'b0, send_s} + {1'b0, answer};
    push_o.m1.kind = ans_kind;
    push_o.m1.seq  = expect_ext;
    push_o.m1.last = 1'b1;
    if (send_s) begin
      push_o.m0.kind = KIND_S;
      push_o.m0.seq  = send_seq_q;
      push_o.m0.last = !answer;
    end else begin
      push_o.m0 = push_o.m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q    <= TICKS_RESET;
      retry_q    <= RETRY_RESET;
      phase_q    <= 16'd0;
      wait_q     <= 8'd0;
      send_seq_q <= 8'd1;
      expect_q   <= 7'd1;
      cleared_q  <= 1'b0;
      count_q    <= 2'd0;
      head_q     <= 8'd0;
      tail_q     <= 8'd0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_TICKS) ticks_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == CFG_RETRY) retry_q <= cfg_data_i[7:0];
      phase_q    <= phase_d;
      wait_q     <= wait_d;
      send_seq_q <= send_seq_d;
      expect_q   <= expect_d;
      cleared_q  <= cleared_d;
      count_q    <= count_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
    end
  end

endmodule

// ----- src/swle_msg_fifo.sv -----
// short message queue between front and back, two writes and one read per cycle
module swle_msg_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  swle_pkg::push_t  push_i,
  output logic             space_o,
  input  logic             pop_i,
  output logic             valid_o,
  output swle_pkg::msg_t   data_o
);
  import swle_pkg::*;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);
  localparam int unsigned QCw    = $clog2(QDepth + 1);

  msg_t           mem_q [QDepth];
  logic [QAw-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAw-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCw-1:0] cnt_q, cnt_d;
  logic [QAw-1:0] wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_q + QAw'(1);
  assign valid_o   = (cnt_q != '0);
  assign data_o    = mem_q[rd_ptr_q];
  assign space_o   = (cnt_q <= QCw'(QDepth - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + QAw'(push_i.num);
    rd_ptr_d = pop_i ? rd_ptr_q + QAw'(1) : rd_ptr_q;
    cnt_d    = cnt_q + QCw'(push_i.num) - QCw'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) mem_q[wr_ptr_q]  <= push_i.m0;
    if (push_i.num == 2'd2) mem_q[wr_ptr_p1] <= push_i.m1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ----- src/swle_back.sv -----
// back end: drains the queue into the output register
module swle_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  swle_pkg::msg_t   q_data_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output swle_pkg::msg_t   out_o
);
  import swle_pkg::*;

  logic out_valid_q, out_valid_d;
  msg_t out_q;

  assign q_pop_o     = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    if (q_pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) out_q <= q_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

endmodule
